// ===== rtl/fpm_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the phase PWM modulator.
`default_nettype none

package fpm_pkg;

   // Field and register widths
   localparam int UQ_W       = 15;
   localparam int ANGLE_W    = 16;
   localparam int POS_W      = ANGLE_W - 2;
   localparam int LIMIT_W    = 14;
   localparam int SUPPLY_W   = 14;
   localparam int PERIOD_W   = 16;
   localparam int COMPARE_W  = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPLY      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD      = 2'd2;

   // Reset values of the configuration registers
   localparam logic [LIMIT_W-1:0]  PHASE_LIMIT_RESET = 14'd3072;
   localparam logic [SUPPLY_W-1:0] SUPPLY_RESET      = 14'd3072;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET      = 16'd4799;

   // Sine table: quarter wave, SINE_TABLE_DEPTH+1 entries in Q0.15
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int ROM_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SINE_W    = 15;
   localparam logic [ROM_IDX_W-1:0] ROM_LAST = ROM_IDX_W'(SINE_TABLE_DEPTH);

   // Transform arithmetic
   localparam int AB_W       = 31;   // alpha and beta, Q23 volts
   localparam int KB_W       = 32;   // sqrt(3)/2 * beta, Q24 volts
   localparam int RAW_W      = 34;   // unclamped phase, Q24 volts
   localparam int PHASE_W    = 30;   // clamped phase, Q24 volts, unsigned
   localparam int VOLT_SHIFT = 16;   // Q8 register volts to Q24 phase volts
   localparam logic signed [16:0] SQRT3_HALF_Q16 = 17'sd56756;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Pipelined restoring divider
   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES         = COMPARE_W / DIV_BITS_PER_STAGE;
   localparam int REM_W              = SUPPLY_W;

   // Polynomial coefficients for the table, Q30
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR3_Q30 = 64'd693598668;
   localparam logic [63:0] TAYLOR5_Q30 = 64'd85569306;
   localparam logic [63:0] TAYLOR7_Q30 = 64'd5026993;
   localparam logic [63:0] TAYLOR9_Q30 = 64'd172272;

   typedef logic [SINE_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   typedef struct packed {
      logic [LIMIT_W-1:0]  phase_limit;
      logic [SUPPLY_W-1:0] supply;
      logic [PERIOD_W-1:0] period;
   } fpm_cfg_type;

   // One phase as it crosses the queue: (phase * period) >> 16 and a full-duty flag
   typedef struct packed {
      logic [PHASE_W-1:0] prod;
      logic               full;
   } fpm_phase_type;

   typedef fpm_phase_type [2:0] fpm_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fpm_qstat_type;

   // sin(pi/2 * k/DEPTH) in Q15 by the odd 9th-order polynomial
   function automatic logic [SINE_W-1:0] quarter_sine(int unsigned k);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] r;
      u  = (64'(k) << 30) / 64'(SINE_TABLE_DEPTH);
      u2 = (u * u) >> 30;
      p  = TAYLOR9_Q30;
      p  = TAYLOR7_Q30 - ((u2 * p) >> 30);
      p  = TAYLOR5_Q30 - ((u2 * p) >> 30);
      p  = TAYLOR3_Q30 - ((u2 * p) >> 30);
      p  = PI_HALF_Q30 - ((u2 * p) >> 30);
      s  = (u * p) >> 30;
      r  = (s + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[SINE_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         rom[k] = quarter_sine(k);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/fpm_front.sv =====
// Front pipeline: takes commands, reads sine and cosine, transforms, clamps and scales phases.
`default_nettype none

module fpm_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire fpm_pkg::fpm_cfg_type             cfg,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [fpm_pkg::UQ_W-1:0]  req_uq_voltage,
   input  wire logic [fpm_pkg::ANGLE_W-1:0]      req_elec_angle,
   input  wire fpm_pkg::fpm_qstat_type           qstat,
   output logic                                  push,
   output fpm_pkg::fpm_entry_type                push_entry
);

   localparam int PROD_W = fpm_pkg::POS_W + fpm_pkg::ROM_IDX_W;
   localparam int MUL_W  = fpm_pkg::PHASE_W + fpm_pkg::PERIOD_W;

   typedef struct packed {
      logic [fpm_pkg::PHASE_W-1:0] volt;
      logic                        full;
   } volt_type;

   // Offset by half supply, clamp to 0..limit, flag full duty
   function automatic volt_type clamp_phase(logic signed [fpm_pkg::RAW_W-1:0] raw,
                                            fpm_pkg::fpm_cfg_type c);
      volt_type                          v;
      logic signed [fpm_pkg::RAW_W-1:0]  x;
      logic signed [fpm_pkg::RAW_W-1:0]  lim;
      logic signed [fpm_pkg::RAW_W-1:0]  offset;
      logic [fpm_pkg::PHASE_W-1:0]       full_scale;
      offset     = $signed(fpm_pkg::RAW_W'({c.supply, {(fpm_pkg::VOLT_SHIFT-1){1'b0}}}));
      lim        = $signed(fpm_pkg::RAW_W'({c.phase_limit, {fpm_pkg::VOLT_SHIFT{1'b0}}}));
      full_scale = {c.supply, {fpm_pkg::VOLT_SHIFT{1'b0}}};
      x = raw + offset;
      if (x < 0) begin
         x = '0;
      end else if (x > lim) begin
         x = lim;
      end
      v.volt = x[fpm_pkg::PHASE_W-1:0];
      v.full = v.volt >= full_scale;
      return v;
   endfunction

   logic f_adv;

   logic                                f1_valid_ff;
   logic signed [fpm_pkg::UQ_W-1:0]     f1_uq_ff;
   logic [fpm_pkg::ANGLE_W-1:0]         f1_angle_ff;

   logic                                f2_valid_ff;
   logic signed [fpm_pkg::UQ_W-1:0]     f2_uq_ff;
   logic [fpm_pkg::SINE_W-1:0]          f2_sin_ff;
   logic [fpm_pkg::SINE_W-1:0]          f2_cos_ff;
   logic                                f2_sin_neg_ff;
   logic                                f2_cos_neg_ff;

   logic                                f3_valid_ff;
   logic signed [fpm_pkg::AB_W-1:0]     f3_alpha_ff;
   logic signed [fpm_pkg::AB_W-1:0]     f3_beta_ff;

   logic                                f4_valid_ff;
   logic signed [fpm_pkg::AB_W-1:0]     f4_alpha_ff;
   logic signed [fpm_pkg::KB_W-1:0]     f4_kb_ff;

   logic                                f5_valid_ff;
   volt_type [2:0]                      f5_volt_ff;

   // Table addressing for sine and cosine (cosine is one quadrant ahead)
   logic [1:0]                          sin_quad;
   logic [1:0]                          cos_quad;
   logic [PROD_W-1:0]                   idx_prod;
   logic [fpm_pkg::ROM_IDX_W-1:0]       idx_base;
   logic [fpm_pkg::ROM_IDX_W-1:0]       sin_idx;
   logic [fpm_pkg::ROM_IDX_W-1:0]       cos_idx;

   // Products
   logic signed [fpm_pkg::SINE_W:0]     alpha_factor;
   logic signed [fpm_pkg::SINE_W:0]     beta_factor;
   logic signed [fpm_pkg::AB_W-1:0]     alpha_in;
   logic signed [fpm_pkg::AB_W-1:0]     beta_in;
   logic signed [47:0]                  kb_prod;
   logic signed [fpm_pkg::RAW_W-1:0]    raw_a;
   logic signed [fpm_pkg::RAW_W-1:0]    raw_b;
   logic signed [fpm_pkg::RAW_W-1:0]    raw_c;
   volt_type [2:0]                      volt_in;
   logic [MUL_W-1:0]                    duty_prod [3];

   // Advance the whole front unless its last stage waits on a full queue
   assign f_adv     = !f5_valid_ff || !qstat.full;
   assign req_stall = !f_adv;
   assign push      = f5_valid_ff && !qstat.full;

   always_comb begin
      sin_quad = f1_angle_ff[fpm_pkg::ANGLE_W-1 -: 2];
      cos_quad = sin_quad + 2'd1;
      idx_prod = PROD_W'(f1_angle_ff[fpm_pkg::POS_W-1:0]) * PROD_W'(fpm_pkg::SINE_TABLE_DEPTH);
      idx_base = idx_prod[PROD_W-1:fpm_pkg::POS_W];
      sin_idx  = sin_quad[0] ? fpm_pkg::ROM_LAST - idx_base : idx_base;
      cos_idx  = cos_quad[0] ? fpm_pkg::ROM_LAST - idx_base : idx_base;
   end

   // alpha = -uq*sin, beta = uq*cos
   always_comb begin
      alpha_factor = f2_sin_neg_ff ? $signed({1'b0, f2_sin_ff}) : -$signed({1'b0, f2_sin_ff});
      beta_factor  = f2_cos_neg_ff ? -$signed({1'b0, f2_cos_ff}) : $signed({1'b0, f2_cos_ff});
      alpha_in     = fpm_pkg::AB_W'(f2_uq_ff) * fpm_pkg::AB_W'(alpha_factor);
      beta_in      = fpm_pkg::AB_W'(f2_uq_ff) * fpm_pkg::AB_W'(beta_factor);
   end

   assign kb_prod = 48'(f3_beta_ff) * 48'(fpm_pkg::SQRT3_HALF_Q16);

   // Inverse Clarke in Q24, then offset and clamp each phase
   always_comb begin
      raw_a = fpm_pkg::RAW_W'(f4_alpha_ff) <<< 1;
      raw_b = fpm_pkg::RAW_W'(f4_kb_ff) - fpm_pkg::RAW_W'(f4_alpha_ff);
      raw_c = -fpm_pkg::RAW_W'(f4_alpha_ff) - fpm_pkg::RAW_W'(f4_kb_ff);
      volt_in[0] = clamp_phase(raw_a, cfg);
      volt_in[1] = clamp_phase(raw_b, cfg);
      volt_in[2] = clamp_phase(raw_c, cfg);
   end

   // Scale by the period and drop the 16 fraction bits of the supply scale
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         duty_prod[i]       = MUL_W'(f5_volt_ff[i].volt) * MUL_W'(cfg.period);
         push_entry[i].prod = duty_prod[i][MUL_W-1:fpm_pkg::VOLT_SHIFT];
         push_entry[i].full = f5_volt_ff[i].full;
      end
   end

   // Hold stage valids; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
         f5_valid_ff <= 1'b0;
      end else if (f_adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
         f5_valid_ff <= f4_valid_ff;
      end
   end

   // Advance stage payloads; table reads are registered here
   always_ff @(posedge clock) begin
      if (f_adv) begin
         f1_uq_ff      <= req_uq_voltage;
         f1_angle_ff   <= req_elec_angle;
         f2_uq_ff      <= f1_uq_ff;
         f2_sin_ff     <= fpm_pkg::SINE_ROM[sin_idx];
         f2_cos_ff     <= fpm_pkg::SINE_ROM[cos_idx];
         f2_sin_neg_ff <= sin_quad[1];
         f2_cos_neg_ff <= cos_quad[1];
         f3_alpha_ff   <= alpha_in;
         f3_beta_ff    <= beta_in;
         f4_alpha_ff   <= f3_alpha_ff;
         f4_kb_ff      <= kb_prod[46:15];
         f5_volt_ff    <= volt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fpm_queue.sv =====
// Short queue that decouples the transform front from the divider back.
`default_nettype none

module fpm_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire fpm_pkg::fpm_entry_type push_entry,
   input  wire logic                   pop,
   output fpm_pkg::fpm_entry_type      pop_entry,
   output fpm_pkg::fpm_qstat_type      qstat
);

   fpm_pkg::fpm_entry_type          slot_ff [fpm_pkg::QUEUE_DEPTH];
   logic [fpm_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [fpm_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [fpm_pkg::QPTR_W:0]        count_ff;
   logic [fpm_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [fpm_pkg::QPTR_W-1:0]      rd_ptr_in;

   localparam logic [fpm_pkg::QPTR_W-1:0] PTR_LAST = fpm_pkg::QPTR_W'(fpm_pkg::QUEUE_DEPTH - 1);
   localparam logic [fpm_pkg::QPTR_W:0]   COUNT_FULL = (fpm_pkg::QPTR_W+1)'(fpm_pkg::QUEUE_DEPTH);

   assign qstat.full  = count_ff == COUNT_FULL;
   assign qstat.empty = count_ff == '0;
   assign pop_entry   = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   // Move pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store the entry on push
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fpm_back.sv =====
// Back pipeline: divides each scaled phase by the supply and forms the compare values.
`default_nettype none

module fpm_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire fpm_pkg::fpm_cfg_type             cfg,
   input  wire fpm_pkg::fpm_qstat_type           qstat,
   input  wire fpm_pkg::fpm_entry_type           pop_entry,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [fpm_pkg::COMPARE_W-1:0]         rsp_compare_a,
   output logic [fpm_pkg::COMPARE_W-1:0]         rsp_compare_b,
   output logic [fpm_pkg::COMPARE_W-1:0]         rsp_compare_c
);

   // Remainder and a shared dividend/quotient shift register per phase
   typedef struct packed {
      logic [fpm_pkg::REM_W-1:0]     rem;
      logic [fpm_pkg::COMPARE_W-1:0] dq;
      logic                          full;
   } lane_type;

   typedef lane_type [2:0] lanes_type;

   // Several restoring division steps on one lane
   function automatic lane_type div_steps(lane_type lane, logic [fpm_pkg::SUPPLY_W-1:0] divisor);
      lane_type                    res;
      logic [fpm_pkg::REM_W:0]     trial;
      logic                        ge;
      res = lane;
      for (int i = 0; i < fpm_pkg::DIV_BITS_PER_STAGE; i++) begin
         trial   = {res.rem, res.dq[fpm_pkg::COMPARE_W-1]};
         ge      = trial >= {1'b0, divisor};
         res.dq  = {res.dq[fpm_pkg::COMPARE_W-2:0], ge};
         res.rem = ge ? fpm_pkg::REM_W'(trial - {1'b0, divisor}) : trial[fpm_pkg::REM_W-1:0];
      end
      return res;
   endfunction

   // Full duty maps to the period; then subtract one, saturating at zero
   function automatic logic [fpm_pkg::COMPARE_W-1:0] finish(lane_type lane,
                                                           logic [fpm_pkg::PERIOD_W-1:0] period);
      logic [fpm_pkg::COMPARE_W-1:0] n;
      n = lane.full ? period : lane.dq;
      return (n == '0) ? '0 : n - 1'b1;
   endfunction

   logic                              b_adv;
   logic [fpm_pkg::DIV_STAGES:0]      stage_valid_ff;
   lanes_type                         stage_ff [fpm_pkg::DIV_STAGES+1];
   lanes_type                         stage_in [fpm_pkg::DIV_STAGES+1];
   logic                              out_valid_ff;
   logic [fpm_pkg::COMPARE_W-1:0]     out_a_ff;
   logic [fpm_pkg::COMPARE_W-1:0]     out_b_ff;
   logic [fpm_pkg::COMPARE_W-1:0]     out_c_ff;

   // Advance everything when the output register is free or being taken
   assign b_adv         = !out_valid_ff || !rsp_stall;
   assign pop           = b_adv && !qstat.empty;
   assign rsp_valid     = out_valid_ff;
   assign rsp_compare_a = out_a_ff;
   assign rsp_compare_b = out_b_ff;
   assign rsp_compare_c = out_c_ff;

   // Load stage splits the dividend; later stages each retire a few quotient bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         stage_in[0][i].rem  = pop_entry[i].prod[fpm_pkg::PHASE_W-1:fpm_pkg::COMPARE_W];
         stage_in[0][i].dq   = pop_entry[i].prod[fpm_pkg::COMPARE_W-1:0];
         stage_in[0][i].full = pop_entry[i].full;
      end
      for (int k = 1; k <= fpm_pkg::DIV_STAGES; k++) begin
         for (int i = 0; i < 3; i++) begin
            stage_in[k][i] = div_steps(stage_ff[k-1][i], cfg.supply);
         end
      end
   end

   // Shift valids through the divider and into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else if (b_adv) begin
         stage_valid_ff <= {stage_valid_ff[fpm_pkg::DIV_STAGES-1:0], !qstat.empty};
         out_valid_ff   <= stage_valid_ff[fpm_pkg::DIV_STAGES];
      end
   end

   // Advance payloads; hold the output while stalled
   always_ff @(posedge clock) begin
      if (b_adv) begin
         for (int k = 0; k <= fpm_pkg::DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         out_a_ff <= finish(stage_ff[fpm_pkg::DIV_STAGES][0], cfg.period);
         out_b_ff <= finish(stage_ff[fpm_pkg::DIV_STAGES][1], cfg.period);
         out_c_ff <= finish(stage_ff[fpm_pkg::DIV_STAGES][2], cfg.period);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/foc_phase_pwm_modulator_top.sv =====
// Top level of the sinusoidal phase PWM modulator: configuration registers and the pipeline.
//
// Takes a signed Q7.8 q-axis voltage and a 16-bit electrical angle and returns three timer
// compare values, one result per command. Sine and cosine come from a quarter-wave table,
// followed by inverse Park (d-axis zero) and inverse Clarke, an offset of half the supply,
// a clamp to the phase limit and duty = phase / supply scaled by the period, minus one.
// The block is fully pipelined and takes a new command every cycle while req_stall is low.
// A command passes through five transform stages, the four-entry queue, the five-stage
// divider that divides by the supply voltage (a load stage, then four stages of four quotient
// bits) and the output register. While the output is stalled the divider holds and the queue
// fills; then req_stall rises. Write the configuration registers only while no command is in
// flight.
`default_nettype none

module foc_phase_pwm_modulator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [fpm_pkg::UQ_W-1:0]      req_uq_voltage,
   input  wire logic [fpm_pkg::ANGLE_W-1:0]          req_elec_angle,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [fpm_pkg::COMPARE_W-1:0]             rsp_compare_a,
   output logic [fpm_pkg::COMPARE_W-1:0]             rsp_compare_b,
   output logic [fpm_pkg::COMPARE_W-1:0]             rsp_compare_c,
   input  wire logic                                 csr_wr_en,
   input  wire logic [fpm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [fpm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [fpm_pkg::LIMIT_W-1:0]   phase_limit_ff;
   logic [fpm_pkg::SUPPLY_W-1:0]  supply_ff;
   logic [fpm_pkg::PERIOD_W-1:0]  period_ff;
   fpm_pkg::fpm_cfg_type          cfg;
   fpm_pkg::fpm_qstat_type        qstat;
   fpm_pkg::fpm_entry_type        push_entry;
   fpm_pkg::fpm_entry_type        pop_entry;
   logic                          push;
   logic                          pop;

   // Configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_limit_ff <= fpm_pkg::PHASE_LIMIT_RESET;
         supply_ff      <= fpm_pkg::SUPPLY_RESET;
         period_ff      <= fpm_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fpm_pkg::CSR_PHASE_LIMIT: phase_limit_ff <= csr_wdata[fpm_pkg::LIMIT_W-1:0];
            fpm_pkg::CSR_SUPPLY:      supply_ff      <= csr_wdata[fpm_pkg::SUPPLY_W-1:0];
            fpm_pkg::CSR_PERIOD:      period_ff      <= csr_wdata[fpm_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.phase_limit = phase_limit_ff;
   assign cfg.supply      = supply_ff;
   assign cfg.period      = period_ff;

   fpm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_uq_voltage (req_uq_voltage),
      .req_elec_angle (req_elec_angle),
      .qstat          (qstat),
      .push           (push),
      .push_entry     (push_entry)
   );

   fpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   fpm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .qstat         (qstat),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_compare_a (rsp_compare_a),
      .rsp_compare_b (rsp_compare_b),
      .rsp_compare_c (rsp_compare_c)
   );

endmodule

`default_nettype wire

// ===== rtl/fpm_checker.sv =====
// Port-level checker for the phase PWM modulator, bound to the top level.
`default_nettype none

module fpm_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [fpm_pkg::COMPARE_W-1:0]        rsp_compare_a,
   input wire logic [fpm_pkg::COMPARE_W-1:0]        rsp_compare_b,
   input wire logic [fpm_pkg::COMPARE_W-1:0]        rsp_compare_c,
   input wire logic                                 csr_wr_en,
   input wire logic [fpm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input wire logic [fpm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [fpm_pkg::PERIOD_W-1:0] period_ff;
   logic [4:0]                   pending_ff;
   logic                         in_xfer;
   logic                         out_xfer;
   logic                         in_range;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;

   // Every compare value stays below the period, or is zero at a zero period
   assign in_range = (period_ff == '0)
                   ? (rsp_compare_a == '0 && rsp_compare_b == '0 && rsp_compare_c == '0)
                   : (rsp_compare_a < period_ff && rsp_compare_b < period_ff &&
                      rsp_compare_c < period_ff);

   // Shadow the period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= fpm_pkg::PERIOD_RESET;
      end else if (csr_wr_en && csr_index == fpm_pkg::CSR_PERIOD) begin
         period_ff <= csr_wdata[fpm_pkg::PERIOD_W-1:0];
      end
   end

   // Count transfers in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (in_xfer && !out_xfer) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (out_xfer && !in_xfer) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_compare_a) &&
                                 $stable(rsp_compare_b) && $stable(rsp_compare_c))
      else $error("stalled result changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without an outstanding command");

   a_compare_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> in_range)
      else $error("compare value outside the PWM period");

endmodule

bind foc_phase_pwm_modulator_top fpm_checker u_fpm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_compare_a (rsp_compare_a),
   .rsp_compare_b (rsp_compare_b),
   .rsp_compare_c (rsp_compare_c),
   .csr_wr_en     (csr_wr_en),
   .csr_index     (csr_index),
   .csr_wdata     (csr_wdata)
);

`default_nettype wire

// ===== dv/foc_phase_pwm_modulator_top_tb.sv =====
// Testbench of the phase PWM modulator: random traffic checked against a built-in predictor.
`default_nettype none

module foc_phase_pwm_modulator_top_tb;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 12;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          IDLE_PERCENT = 13;
   localparam int          PHASE_COUNT  = 12;
   localparam int          PHASE_ITEMS  = 80;
   localparam longint      ROOT3_HALF_Q16 = 56756;

   // Quarter-wave polynomial coefficients, Q30
   localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam bit [63:0] POLY3_Q30   = 64'd693598668;
   localparam bit [63:0] POLY5_Q30   = 64'd85569306;
   localparam bit [63:0] POLY7_Q30   = 64'd5026993;
   localparam bit [63:0] POLY9_Q30   = 64'd172272;

   typedef struct packed {
      logic [fpm_pkg::COMPARE_W-1:0] a;
      logic [fpm_pkg::COMPARE_W-1:0] b;
      logic [fpm_pkg::COMPARE_W-1:0] c;
   } compare_triple_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic signed [fpm_pkg::UQ_W-1:0] req_uq_voltage;
   logic [fpm_pkg::ANGLE_W-1:0]     req_elec_angle;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [fpm_pkg::COMPARE_W-1:0]   rsp_compare_a;
   logic [fpm_pkg::COMPARE_W-1:0]   rsp_compare_b;
   logic [fpm_pkg::COMPARE_W-1:0]   rsp_compare_c;
   logic                            csr_wr_en;
   logic [fpm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fpm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   bit                              no_idle;
   int unsigned                     cycle_count;

   // Predicts compare values from the current register copy and checks results in order
   class compare_scoreboard;
      longint             limit_v;
      longint             supply_v;
      longint             period_v;
      longint             quarter_wave[fpm_pkg::SINE_TABLE_DEPTH+1];
      compare_triple_type pending_compares[$];
      bit                 failed;

      function new();
         bit [63:0] u;
         bit [63:0] u2;
         bit [63:0] p;
         bit [63:0] s;
         bit [63:0] r;
         for (int k = 0; k <= fpm_pkg::SINE_TABLE_DEPTH; k++) begin
            u  = (64'(k) << 30) / 64'(fpm_pkg::SINE_TABLE_DEPTH);
            u2 = (u * u) >> 30;
            p  = POLY9_Q30;
            p  = POLY7_Q30 - ((u2 * p) >> 30);
            p  = POLY5_Q30 - ((u2 * p) >> 30);
            p  = POLY3_Q30 - ((u2 * p) >> 30);
            p  = HALF_PI_Q30 - ((u2 * p) >> 30);
            s  = (u * p) >> 30;
            r  = (s + 64'd16384) >> 15;
            if (r > 64'd32767) begin
               r = 64'd32767;
            end
            quarter_wave[k] = longint'(r);
         end
         limit_v  = longint'(fpm_pkg::PHASE_LIMIT_RESET);
         supply_v = longint'(fpm_pkg::SUPPLY_RESET);
         period_v = longint'(fpm_pkg::PERIOD_RESET);
         failed   = 1'b0;
      endfunction

      function void set_config(logic [fpm_pkg::CSR_DATA_W-1:0] limit_raw,
                               logic [fpm_pkg::CSR_DATA_W-1:0] supply_raw,
                               logic [fpm_pkg::CSR_DATA_W-1:0] period_raw);
         limit_v  = longint'(limit_raw[fpm_pkg::LIMIT_W-1:0]);
         supply_v = longint'(supply_raw[fpm_pkg::SUPPLY_W-1:0]);
         period_v = longint'(period_raw[fpm_pkg::PERIOD_W-1:0]);
      endfunction

      // Q15 sine from the quarter wave: mirror odd quadrants, negate the lower half turn
      function longint sine_q15(logic [fpm_pkg::ANGLE_W-1:0] ang);
         longint unsigned idx;
         idx = (longint'(ang[fpm_pkg::POS_W-1:0]) * fpm_pkg::SINE_TABLE_DEPTH) >> fpm_pkg::POS_W;
         if (ang[fpm_pkg::POS_W]) begin
            idx = fpm_pkg::SINE_TABLE_DEPTH - idx;
         end
         return ang[fpm_pkg::POS_W+1] ? -quarter_wave[idx] : quarter_wave[idx];
      endfunction

      // Offset by half supply, clamp, scale duty by the period, subtract one
      function logic [fpm_pkg::COMPARE_W-1:0] phase_to_compare(longint volts_q24);
         longint x;
         longint lim;
         longint full;
         longint n;
         x    = volts_q24 + (supply_v <<< 15);
         lim  = limit_v <<< 16;
         full = supply_v <<< 16;
         if (x < 0) begin
            x = 0;
         end
         if (x > lim) begin
            x = lim;
         end
         if (x >= full) begin
            n = period_v;
         end else begin
            n = (x * period_v) / full;
         end
         return (n > 0) ? fpm_pkg::COMPARE_W'(n - 1) : '0;
      endfunction

      function compare_triple_type modulate(logic signed [fpm_pkg::UQ_W-1:0] uq,
                                            logic [fpm_pkg::ANGLE_W-1:0] ang);
         longint             q;
         longint             alpha;
         longint             beta;
         longint             kb;
         compare_triple_type res;
         q     = longint'(uq);
         alpha = -(q * sine_q15(ang));
         beta  = q * sine_q15(ang + fpm_pkg::ANGLE_W'(16384));
         kb    = (beta * ROOT3_HALF_Q16) >>> 15;
         res.a = phase_to_compare(2 * alpha);
         res.b = phase_to_compare(-alpha + kb);
         res.c = phase_to_compare(-alpha - kb);
         return res;
      endfunction

      function void note_command(logic signed [fpm_pkg::UQ_W-1:0] uq,
                                 logic [fpm_pkg::ANGLE_W-1:0] ang);
         pending_compares.push_back(modulate(uq, ang));
      endfunction

      function void check_field(string name, logic [fpm_pkg::COMPARE_W-1:0] exp_v,
                                logic [fpm_pkg::COMPARE_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            failed = 1'b1;
         end
      endfunction

      function void check_result(compare_triple_type act);
         compare_triple_type exp_t;
         if (pending_compares.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                     $time, act.a, act.b, act.c);
            failed = 1'b1;
         end else begin
            exp_t = pending_compares.pop_front();
            check_field("compare_a", exp_t.a, act.a);
            check_field("compare_b", exp_t.b, act.b);
            check_field("compare_c", exp_t.c, act.c);
         end
      endfunction
   endclass

   compare_scoreboard sb;

   foc_phase_pwm_modulator_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_uq_voltage (req_uq_voltage),
      .req_elec_angle (req_elec_angle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_compare_a  (rsp_compare_a),
      .rsp_compare_b  (rsp_compare_b),
      .rsp_compare_c  (rsp_compare_c),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
   end
   always #(HALF_PERIOD) clock = ~clock;

   function automatic bit take_break();
      return !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= take_break();
   end

   // Note accepted commands and check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_command(req_uq_voltage, req_elec_angle);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result('{rsp_compare_a, rsp_compare_b, rsp_compare_c});
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Hold one command until transferred; valid stays high for the next one
   task automatic send_command(input int uq, input int ang);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_uq_voltage <= fpm_pkg::UQ_W'(uq);
      req_elec_angle <= fpm_pkg::ANGLE_W'(ang);
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Wait for all results, then for the pipeline to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_compares.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back while idle
   task automatic write_registers(input int limit_raw, input int supply_raw,
                                  input int period_raw);
      sb.set_config(fpm_pkg::CSR_DATA_W'(limit_raw), fpm_pkg::CSR_DATA_W'(supply_raw),
                    fpm_pkg::CSR_DATA_W'(period_raw));
      csr_wr_en <= 1'b1;
      csr_index <= fpm_pkg::CSR_PHASE_LIMIT;
      csr_wdata <= fpm_pkg::CSR_DATA_W'(limit_raw);
      @(posedge clock);
      csr_index <= fpm_pkg::CSR_SUPPLY;
      csr_wdata <= fpm_pkg::CSR_DATA_W'(supply_raw);
      @(posedge clock);
      csr_index <= fpm_pkg::CSR_PERIOD;
      csr_wdata <= fpm_pkg::CSR_DATA_W'(period_raw);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random commands, biased toward extremes and quadrant boundaries
   task automatic send_random(input int count);
      int uq;
      int ang;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       uq = -16384;
            1:       uq = 16383;
            2:       uq = int'($urandom_range(0, 511)) - 256;
            default: uq = int'($urandom_range(0, 32767)) - 16384;
         endcase
         case ($urandom_range(0, 7))
            0:       ang = int'($urandom_range(0, 3)) * 16384 + int'($urandom_range(0, 2)) - 1;
            default: ang = int'($urandom_range(0, 65535));
         endcase
         send_command(uq, ang);
      end
   endtask

   initial begin
      int lim_w;
      int sup_w;
      int per_w;
      sb             = new();
      no_idle        = 1'b0;
      cycle_count    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_uq_voltage = '0;
      req_elec_angle = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = fpm_pkg::CSR_PHASE_LIMIT;
      csr_wdata      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and quadrant edges at reset register values
      send_command(0, 0);
      send_command(16383, 0);
      send_command(-16384, 0);
      send_command(16383, 16384);
      send_command(-16384, 16384);
      send_command(16383, 32768);
      send_command(-16384, 49152);
      send_command(16383, 65535);
      send_command(-16384, 65535);
      send_command(16383, 16383);
      send_command(-1, 8192);
      send_command(1, 24576);
      send_command(256, 40960);
      send_command(-256, 57344);
      send_command(16383, 5461);
      send_command(-16384, 27307);
      send_command(12000, 21845);
      send_command(-12000, 43690);
      drain();

      // Random phases over several register settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         lim_w = int'($urandom_range(0, 65535));
         sup_w = int'($urandom_range(0, 65535));
         per_w = int'($urandom_range(0, 65535));
         case (p)
            0: begin  // limit far above supply: duty saturates
               lim_w = 16383;
               sup_w = 1;
               per_w = 65535;
            end
            1: begin
               lim_w = 0;
               sup_w = 16383;
               per_w = 1;
            end
            2: begin  // zero supply: full duty everywhere
               sup_w = 0;
               per_w = 65535;
            end
            3: per_w = 0;  // zero period: all compares zero
            4: begin
               lim_w = 16383;
               sup_w = 16383;
               per_w = 65535;
            end
            5: begin
               lim_w = int'(fpm_pkg::PHASE_LIMIT_RESET);
               sup_w = int'(fpm_pkg::SUPPLY_RESET);
               per_w = int'(fpm_pkg::PERIOD_RESET);
            end
            default: ;
         endcase
         no_idle = (p == 6) || (p == 7);
         write_registers(lim_w, sup_w, per_w);
         send_random(PHASE_ITEMS);
         drain();
      end

      if (!sb.failed && sb.pending_compares.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
